FILE: hdl/upmx_pkg.sv
// ----------------------------------------------------------------------------
// upmx_pkg
// Shared types, constants and helpers for the stereo to 5.1 upmixer core.
// ----------------------------------------------------------------------------
package upmx_pkg;

   // sample and arithmetic widths
   localparam int SAMPLE_W  = 24;
   localparam int COEF_W    = 32;
   localparam int PROD_W    = SAMPLE_W + COEF_W;
   // five products of at most 2^54 each fit in 58 bits
   localparam int ACC_W     = PROD_W + 2;

   // number of chained biquad sections on the lfe path
   localparam int FILTER_STAGES = 3;
   localparam int STAGE_W = (FILTER_STAGES > 1) ? $clog2(FILTER_STAGES) : 1;

   // rounding shifts for gains (q1.23) and coefficients (q2.30)
   localparam int GAIN_SHIFT = 23;
   localparam int COEF_SHIFT = 30;

   // fixed gains in q1.23
   localparam logic signed [COEF_W-1:0] GAIN_M4DB = 32'sd5292851;
   localparam logic signed [COEF_W-1:0] GAIN_M2DB = 32'sd6663306;

   // saturation bounds on the accumulator scale
   localparam logic signed [ACC_W-1:0] SAT_HI =
      ACC_W'((longint'(1) <<< (SAMPLE_W - 1)) - longint'(1));
   localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

   // register file
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam logic [2:0] CSR_MODE = 3'd0;
   localparam logic [2:0] CSR_B0   = 3'd1;
   localparam logic [2:0] CSR_B1   = 3'd2;
   localparam logic [2:0] CSR_B2   = 3'd3;
   localparam logic [2:0] CSR_A1   = 3'd4;
   localparam logic [2:0] CSR_A2   = 3'd5;

   // coefficient reset values
   localparam logic signed [COEF_W-1:0] RST_B0 = 32'sd2713906;
   localparam logic signed [COEF_W-1:0] RST_B1 = 32'sd5427813;
   localparam logic signed [COEF_W-1:0] RST_B2 = 32'sd2713906;
   localparam logic signed [COEF_W-1:0] RST_A1 = -32'sd1988727133;
   localparam logic signed [COEF_W-1:0] RST_A2 = 32'sd925939787;

   typedef struct packed {
      logic signed [COEF_W-1:0] b0;
      logic signed [COEF_W-1:0] b1;
      logic signed [COEF_W-1:0] b2;
      logic signed [COEF_W-1:0] a1;
      logic signed [COEF_W-1:0] a2;
   } coef_type;

   // one operation for the shared multiply-accumulate unit
   typedef struct packed {
      logic                       valid;
      logic                       clear;
      logic                       negate;
      logic signed [SAMPLE_W-1:0] a;
      logic signed [COEF_W-1:0]   b;
   } mac_op_type;

   typedef enum logic {
      RND_GAIN,
      RND_COEF
   } rnd_sel_type;

   // one six-channel result frame
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left;
      logic signed [SAMPLE_W-1:0] center;
      logic signed [SAMPLE_W-1:0] right;
      logic signed [SAMPLE_W-1:0] left_surround;
      logic signed [SAMPLE_W-1:0] right_surround;
      logic signed [SAMPLE_W-1:0] lfe;
   } frame_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_L,
      ST_MUL_R,
      ST_SAVE_L,
      ST_SAVE_R,
      ST_MUL_C,
      ST_WAIT_C,
      ST_SAVE_C,
      ST_TAP,
      ST_DRAIN,
      ST_STAGE_END,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      TAP_X0,
      TAP_X1,
      TAP_X2,
      TAP_Y1,
      TAP_Y2
   } tap_type;

   // clamp an accumulator-scale value to the sample range
   function automatic logic signed [SAMPLE_W-1:0] sat_sample(
      input logic signed [ACC_W-1:0] v
   );
      logic signed [SAMPLE_W-1:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI[SAMPLE_W-1:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[SAMPLE_W-1:0];
      end else begin
         r = v[SAMPLE_W-1:0];
      end
      return r;
   endfunction

endpackage

FILE: hdl/upmx_mac.sv
// ----------------------------------------------------------------------------
// upmx_mac
// Shared multiply-accumulate unit: one 24x32 signed product per cycle,
// registered, then added to or subtracted from the accumulator, with a
// round-half-up readout at the gain or the coefficient scale.
// ----------------------------------------------------------------------------
module upmx_mac (
   input  logic                                  clock,
   input  logic                                  reset,
   input  upmx_pkg::mac_op_type                  op,
   input  upmx_pkg::rnd_sel_type                 rnd_sel,
   output logic signed [upmx_pkg::ACC_W-1:0]     rnd_wide,
   output logic signed [upmx_pkg::SAMPLE_W-1:0]  rnd_sample
);

   logic signed [upmx_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic                               prod_vld_ff;
   logic                               prod_clr_ff;
   logic                               prod_neg_ff;
   logic signed [upmx_pkg::ACC_W-1:0]  acc_ff, acc_in, acc_base, prod_ext;
   logic signed [upmx_pkg::ACC_W-1:0]  rnd_gain, rnd_coef;

   // multiplier stage
   assign prod_in = upmx_pkg::PROD_W'(op.a) * upmx_pkg::PROD_W'(op.b);

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= op.valid;
      end
      if (op.valid) begin
         prod_ff     <= prod_in;
         prod_clr_ff <= op.clear;
         prod_neg_ff <= op.negate;
      end
   end

   // accumulate stage
   always_comb begin
      prod_ext = upmx_pkg::ACC_W'(prod_ff);
      acc_base = prod_clr_ff ? '0 : acc_ff;
      acc_in   = prod_neg_ff ? (acc_base - prod_ext) : (acc_base + prod_ext);
   end

   always_ff @(posedge clock) begin
      if (prod_vld_ff) begin
         acc_ff <= acc_in;
      end
   end

   // round half up at the selected scale
   always_comb begin
      rnd_gain = (acc_ff + (upmx_pkg::ACC_W'(1) <<< (upmx_pkg::GAIN_SHIFT - 1)))
                 >>> upmx_pkg::GAIN_SHIFT;
      rnd_coef = (acc_ff + (upmx_pkg::ACC_W'(1) <<< (upmx_pkg::COEF_SHIFT - 1)))
                 >>> upmx_pkg::COEF_SHIFT;
      rnd_wide   = (rnd_sel == upmx_pkg::RND_COEF) ? rnd_coef : rnd_gain;
      rnd_sample = upmx_pkg::sat_sample(rnd_wide);
   end

endmodule

FILE: hdl/upmx_seq.sv
// ----------------------------------------------------------------------------
// upmx_seq
// Sequencer for one frame: gain products, then in mode 1 center and the
// chained biquad sections tap by tap, all on the shared multiply-accumulate
// unit. Holds the filter history.
// ----------------------------------------------------------------------------
module upmx_seq (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic signed [upmx_pkg::SAMPLE_W-1:0]  left_in,
   input  logic signed [upmx_pkg::SAMPLE_W-1:0]  right_in,
   input  logic                                  mode,
   input  upmx_pkg::coef_type                    coef,
   input  logic                                  out_free,
   output logic                                  busy,
   output logic                                  done,
   output upmx_pkg::frame_type                   frame
);

   localparam logic [upmx_pkg::STAGE_W-1:0] LAST_STAGE =
      upmx_pkg::STAGE_W'(upmx_pkg::FILTER_STAGES - 1);

   upmx_pkg::state_type state_ff, state_in;
   upmx_pkg::tap_type   tap_ff, tap_in;
   logic [upmx_pkg::STAGE_W-1:0] stage_ff, stage_in;

   logic signed [upmx_pkg::SAMPLE_W-1:0] left_ff, right_ff;
   logic signed [upmx_pkg::SAMPLE_W-1:0] x_cur_ff;
   upmx_pkg::frame_type                  frame_ff;
   logic signed [upmx_pkg::SAMPLE_W-1:0] xh_ff [upmx_pkg::FILTER_STAGES][2];
   logic signed [upmx_pkg::SAMPLE_W-1:0] yh_ff [upmx_pkg::FILTER_STAGES][2];

   upmx_pkg::mac_op_type                 op;
   upmx_pkg::rnd_sel_type                rnd_sel;
   logic signed [upmx_pkg::ACC_W-1:0]    rnd_wide;
   logic signed [upmx_pkg::SAMPLE_W-1:0] rnd_sample;

   upmx_mac u_mac (
      .clock      (clock),
      .reset      (reset),
      .op         (op),
      .rnd_sel    (rnd_sel),
      .rnd_wide   (rnd_wide),
      .rnd_sample (rnd_sample)
   );

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= upmx_pkg::ST_IDLE;
         tap_ff   <= upmx_pkg::TAP_X0;
         stage_ff <= '0;
      end else begin
         state_ff <= state_in;
         tap_ff   <= tap_in;
         stage_ff <= stage_in;
      end
   end

   // next state and unit operations
   always_comb begin
      state_in  = state_ff;
      tap_in    = tap_ff;
      stage_in  = stage_ff;
      op        = '0;
      rnd_sel   = upmx_pkg::RND_GAIN;
      done      = 1'b0;
      unique case (state_ff)
         upmx_pkg::ST_IDLE: begin
            if (start) begin
               state_in = upmx_pkg::ST_MUL_L;
            end
         end
         upmx_pkg::ST_MUL_L: begin
            op.valid = 1'b1;
            op.clear = 1'b1;
            op.a     = left_ff;
            op.b     = upmx_pkg::GAIN_M4DB;
            state_in = upmx_pkg::ST_MUL_R;
         end
         upmx_pkg::ST_MUL_R: begin
            op.valid = 1'b1;
            op.clear = 1'b1;
            op.a     = right_ff;
            op.b     = upmx_pkg::GAIN_M4DB;
            state_in = upmx_pkg::ST_SAVE_L;
         end
         upmx_pkg::ST_SAVE_L: begin
            state_in = upmx_pkg::ST_SAVE_R;
         end
         upmx_pkg::ST_SAVE_R: begin
            state_in = mode ? upmx_pkg::ST_MUL_C : upmx_pkg::ST_DONE;
         end
         upmx_pkg::ST_MUL_C: begin
            op.valid = 1'b1;
            op.clear = 1'b1;
            op.a     = frame_ff.right;
            op.b     = upmx_pkg::GAIN_M2DB;
            state_in = upmx_pkg::ST_WAIT_C;
         end
         upmx_pkg::ST_WAIT_C: begin
            state_in = upmx_pkg::ST_SAVE_C;
         end
         upmx_pkg::ST_SAVE_C: begin
            stage_in = '0;
            tap_in   = upmx_pkg::TAP_X0;
            state_in = upmx_pkg::ST_TAP;
         end
         upmx_pkg::ST_TAP: begin
            op.valid = 1'b1;
            unique case (tap_ff)
               upmx_pkg::TAP_X0: begin
                  op.clear = 1'b1;
                  op.a     = x_cur_ff;
                  op.b     = coef.b0;
                  tap_in   = upmx_pkg::TAP_X1;
               end
               upmx_pkg::TAP_X1: begin
                  op.a   = xh_ff[stage_ff][0];
                  op.b   = coef.b1;
                  tap_in = upmx_pkg::TAP_X2;
               end
               upmx_pkg::TAP_X2: begin
                  op.a   = xh_ff[stage_ff][1];
                  op.b   = coef.b2;
                  tap_in = upmx_pkg::TAP_Y1;
               end
               upmx_pkg::TAP_Y1: begin
                  op.negate = 1'b1;
                  op.a      = yh_ff[stage_ff][0];
                  op.b      = coef.a1;
                  tap_in    = upmx_pkg::TAP_Y2;
               end
               upmx_pkg::TAP_Y2: begin
                  op.negate = 1'b1;
                  op.a      = yh_ff[stage_ff][1];
                  op.b      = coef.a2;
                  tap_in    = upmx_pkg::TAP_X0;
                  state_in  = upmx_pkg::ST_DRAIN;
               end
               default: begin
                  op.valid = 1'b0;
                  tap_in   = upmx_pkg::TAP_X0;
               end
            endcase
         end
         upmx_pkg::ST_DRAIN: begin
            state_in = upmx_pkg::ST_STAGE_END;
         end
         upmx_pkg::ST_STAGE_END: begin
            rnd_sel = upmx_pkg::RND_COEF;
            if (stage_ff == LAST_STAGE) begin
               state_in = upmx_pkg::ST_DONE;
            end else begin
               stage_in = upmx_pkg::STAGE_W'(stage_ff + 1'b1);
               state_in = upmx_pkg::ST_TAP;
            end
         end
         upmx_pkg::ST_DONE: begin
            if (out_free) begin
               done     = 1'b1;
               state_in = upmx_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = upmx_pkg::ST_IDLE;
         end
      endcase
   end

   // input samples and result fields
   always_ff @(posedge clock) begin
      if (state_ff == upmx_pkg::ST_IDLE && start) begin
         left_ff         <= left_in;
         right_ff        <= right_in;
         frame_ff.center <= '0;
         frame_ff.lfe    <= '0;
      end
      if (state_ff == upmx_pkg::ST_SAVE_L) begin
         frame_ff.left          <= rnd_sample;
         frame_ff.left_surround <= upmx_pkg::sat_sample(-rnd_wide);
      end
      if (state_ff == upmx_pkg::ST_SAVE_R) begin
         frame_ff.right          <= rnd_sample;
         frame_ff.right_surround <= upmx_pkg::sat_sample(-rnd_wide);
      end
      // center is twice the rounded product; lfe path starts from its negation
      if (state_ff == upmx_pkg::ST_SAVE_C) begin
         frame_ff.center <= upmx_pkg::sat_sample(rnd_wide <<< 1);
         x_cur_ff <= upmx_pkg::sat_sample(
            -upmx_pkg::ACC_W'(upmx_pkg::sat_sample(rnd_wide <<< 1)));
      end
      // section output feeds the next section
      if (state_ff == upmx_pkg::ST_STAGE_END) begin
         x_cur_ff <= rnd_sample;
         if (stage_ff == LAST_STAGE) begin
            frame_ff.lfe <= rnd_sample;
         end
      end
   end

   // filter history, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < upmx_pkg::FILTER_STAGES; s++) begin
            xh_ff[s][0] <= '0;
            xh_ff[s][1] <= '0;
            yh_ff[s][0] <= '0;
            yh_ff[s][1] <= '0;
         end
      end else if (state_ff == upmx_pkg::ST_STAGE_END) begin
         xh_ff[stage_ff][1] <= xh_ff[stage_ff][0];
         xh_ff[stage_ff][0] <= x_cur_ff;
         yh_ff[stage_ff][1] <= yh_ff[stage_ff][0];
         yh_ff[stage_ff][0] <= rnd_sample;
      end
   end

   assign busy  = (state_ff != upmx_pkg::ST_IDLE);
   assign frame = frame_ff;

endmodule

FILE: hdl/stereo_to_surround_upmixer_core.sv
// ----------------------------------------------------------------------------
// stereo_to_surround_upmixer_core
// Stereo to 5.1 upmixer with a chained biquad low-pass on the lfe channel.
// ----------------------------------------------------------------------------
// One stereo frame in, one six-channel frame out. All arithmetic runs on a
// single 24x32 multiplier with an accumulator behind it, at most one product
// per cycle. When surround_mode is 1 a frame runs through the front gains,
// the center product and each biquad section tap by tap, draining the
// multiply-accumulate pipeline before each section result, then hands the
// frame to the output register and returns to idle; when surround_mode is 0
// only the front gains are computed before the hand-over. The
// input is stalled while a frame is being worked on; a finished frame sits in
// the output register and the next frame can be taken meanwhile. Registers
// must be written only while the block is idle. Filter history is cleared by
// reset and is held while in mode 0.
// ----------------------------------------------------------------------------
module stereo_to_surround_upmixer_core (
   input  logic                                    clock,
   input  logic                                    reset,
   // input channel
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic signed [upmx_pkg::SAMPLE_W-1:0]    req_left_in,
   input  logic signed [upmx_pkg::SAMPLE_W-1:0]    req_right_in,
   // result channel
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [upmx_pkg::SAMPLE_W-1:0]    rsp_left_out,
   output logic signed [upmx_pkg::SAMPLE_W-1:0]    rsp_center_out,
   output logic signed [upmx_pkg::SAMPLE_W-1:0]    rsp_right_out,
   output logic signed [upmx_pkg::SAMPLE_W-1:0]    rsp_left_surround_out,
   output logic signed [upmx_pkg::SAMPLE_W-1:0]    rsp_right_surround_out,
   output logic signed [upmx_pkg::SAMPLE_W-1:0]    rsp_lfe_out,
   // register port
   input  logic                                    csr_psel,
   input  logic                                    csr_penable,
   input  logic                                    csr_pwrite,
   input  logic [upmx_pkg::CSR_ADDR_W-1:0]         csr_paddr,
   input  logic [upmx_pkg::CSR_DATA_W-1:0]         csr_pwdata,
   output logic [upmx_pkg::CSR_DATA_W-1:0]         csr_prdata,
   output logic                                    csr_pready
);

   logic               mode_ff;
   upmx_pkg::coef_type coef_ff;
   logic [2:0]         csr_idx;
   logic               csr_wr;

   logic                busy;
   logic                done;
   logic                out_free;
   upmx_pkg::frame_type frame;
   upmx_pkg::frame_type out_ff;
   logic                out_vld_ff;

   // register writes
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[4:2];
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= 1'b0;
         coef_ff.b0 <= upmx_pkg::RST_B0;
         coef_ff.b1 <= upmx_pkg::RST_B1;
         coef_ff.b2 <= upmx_pkg::RST_B2;
         coef_ff.a1 <= upmx_pkg::RST_A1;
         coef_ff.a2 <= upmx_pkg::RST_A2;
      end else if (csr_wr) begin
         unique case (csr_idx)
            upmx_pkg::CSR_MODE: mode_ff    <= csr_pwdata[0];
            upmx_pkg::CSR_B0:   coef_ff.b0 <= csr_pwdata;
            upmx_pkg::CSR_B1:   coef_ff.b1 <= csr_pwdata;
            upmx_pkg::CSR_B2:   coef_ff.b2 <= csr_pwdata;
            upmx_pkg::CSR_A1:   coef_ff.a1 <= csr_pwdata;
            upmx_pkg::CSR_A2:   coef_ff.a2 <= csr_pwdata;
            default: begin
            end
         endcase
      end
   end

   // register reads
   always_comb begin
      unique case (csr_idx)
         upmx_pkg::CSR_MODE: csr_prdata = {{(upmx_pkg::CSR_DATA_W-1){1'b0}}, mode_ff};
         upmx_pkg::CSR_B0:   csr_prdata = coef_ff.b0;
         upmx_pkg::CSR_B1:   csr_prdata = coef_ff.b1;
         upmx_pkg::CSR_B2:   csr_prdata = coef_ff.b2;
         upmx_pkg::CSR_A1:   csr_prdata = coef_ff.a1;
         upmx_pkg::CSR_A2:   csr_prdata = coef_ff.a2;
         default:            csr_prdata = '0;
      endcase
   end

   // frame sequencer
   assign req_stall = busy;

   upmx_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (req_valid),
      .left_in  (req_left_in),
      .right_in (req_right_in),
      .mode     (mode_ff),
      .coef     (coef_ff),
      .out_free (out_free),
      .busy     (busy),
      .done     (done),
      .frame    (frame)
   );

   // output register, loads when empty or when its frame transfers
   assign out_free = !out_vld_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (done) begin
         out_vld_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_vld_ff <= 1'b0;
      end
      if (done) begin
         out_ff <= frame;
      end
   end

   assign rsp_valid              = out_vld_ff;
   assign rsp_left_out           = out_ff.left;
   assign rsp_center_out         = out_ff.center;
   assign rsp_right_out          = out_ff.right;
   assign rsp_left_surround_out  = out_ff.left_surround;
   assign rsp_right_surround_out = out_ff.right_surround;
   assign rsp_lfe_out            = out_ff.lfe;

endmodule
